[design/stamp_alpha_blend_top_assert.svh]
`ifndef STAMP_ALPHA_BLEND_TOP_ASSERT_SVH
`define STAMP_ALPHA_BLEND_TOP_ASSERT_SVH

// Both macros expect clk and rst_n in scope.
`define SAB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define SAB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/sab_pkg.sv]
`timescale 1ns / 1ps

package sab_pkg;

  localparam int STORE_DEPTH  = 256;
  localparam int FIFO_DEPTH   = 4;
  localparam int CH_NUM       = 4;
  localparam int CH_RED       = 0;
  localparam int CH_GREEN     = 1;
  localparam int CH_BLUE      = 2;
  localparam int CH_ALPHA     = 3;
  localparam int FULL_WEIGHT  = 65280;
  localparam int OPACITY_FULL = 256;
  localparam int ROUND8       = 32640;
  localparam int ROUND16      = 8323200;
  localparam int CH_MAX8      = 255;
  localparam int CH_MAX16     = 32768;
  localparam int DIV_BASE     = 255;
  localparam int RECIP_255    = 16843009;  // floor(2^32 / 255)
  localparam int CFG_W        = 14;
  localparam int CFG_IDX_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOR_RED,
    REG_COLOR_GREEN,
    REG_COLOR_BLUE,
    REG_COLOR_ALPHA,
    REG_OPACITY,
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_DEEP_FORMAT
  } cfg_reg_t;

  typedef enum logic {
    FUNC_LOAD,
    FUNC_BLEND
  } func_t;

  typedef struct packed {
    logic [CH_NUM-1:0][7:0] color;
    logic [8:0]             opacity_q8;
    logic signed [13:0]     center_x;
    logic signed [13:0]     center_y;
    logic                   deep_format;
  } cfg_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  stamp_index;
    logic [7:0]  stamp_value;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [15:0] dst_red;
    logic [15:0] dst_green;
    logic [15:0] dst_blue;
    logic [15:0] dst_alpha;
  } in_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
    logic        touched;
  } out_t;

  typedef struct packed {
    logic [7:0]                   stamp;
    logic [CH_NUM-1:0][15:0]      dst;
  } item_t;

endpackage

[design/sab_if.sv]
`timescale 1ns / 1ps

interface sab_in_if;
  import sab_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sab_out_if;
  import sab_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/sab_front.sv]
`timescale 1ns / 1ps

module sab_front #(
  parameter int STAMP_SIDE = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  sab_pkg::cfg_t  cfg,
  sab_in_if.sink         in_if,
  output logic           push_valid,
  output sab_pkg::item_t push_item,
  input  logic           push_ready
);
  import sab_pkg::*;

  localparam int SIDE_W = (STAMP_SIDE > 1) ? $clog2(STAMP_SIDE) : 1;
  localparam int WIN_W  = 2 * SIDE_W;
  localparam int AREA   = STAMP_SIDE * STAMP_SIDE;
  localparam int HALF   = STAMP_SIDE / 2;

  logic [7:0] stamp_mem [STORE_DEPTH];

  logic                    accept;
  logic                    is_load;
  logic                    load_ok;
  logic signed [15:0]      off_x;
  logic signed [15:0]      off_y;
  logic                    in_x;
  logic                    in_y;
  logic [WIN_W-1:0]        win_addr;
  logic [7:0]              rd_addr;
  logic                    hit;
  logic                    fv_r, fv_nxt;
  logic                    hit_r;
  logic [7:0]              stamp_rd_r;
  logic [CH_NUM-1:0][15:0] dst_r;

  assign accept  = in_if.valid && in_if.ready;
  assign is_load = in_if.data.func == FUNC_LOAD;
  assign load_ok = 32'(in_if.data.stamp_index) < 32'(AREA);

  // window offsets relative to the top-left corner
  assign off_x = 16'($signed({4'd0, in_if.data.pixel_x})) - 16'(cfg.center_x) + 16'(HALF);
  assign off_y = 16'($signed({4'd0, in_if.data.pixel_y})) - 16'(cfg.center_y) + 16'(HALF);
  assign in_x  = !off_x[15] && (off_x < 16'(STAMP_SIDE));
  assign in_y  = !off_y[15] && (off_y < 16'(STAMP_SIDE));

  assign win_addr = WIN_W'(off_y[SIDE_W-1:0]) * WIN_W'(STAMP_SIDE)
                  + WIN_W'(off_x[SIDE_W-1:0]);
  assign rd_addr  = 8'(win_addr);
  assign hit      = in_x && in_y && (32'(win_addr) < 32'(STORE_DEPTH));

  assign in_if.ready = !fv_r || push_ready;

  always_comb begin
    fv_nxt = fv_r;
    if (accept && !is_load) begin
      fv_nxt = 1'b1;
    end else if (push_ready) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_load && load_ok) begin
      stamp_mem[in_if.data.stamp_index] <= in_if.data.stamp_value;
    end
    if (accept && !is_load) begin
      stamp_rd_r <= stamp_mem[rd_addr];
      hit_r      <= hit;
      dst_r      <= {in_if.data.dst_alpha, in_if.data.dst_blue,
                     in_if.data.dst_green, in_if.data.dst_red};
    end
  end

  assign push_valid      = fv_r;
  assign push_item.stamp = hit_r ? stamp_rd_r : 8'd0;
  assign push_item.dst   = dst_r;

endmodule

[design/sab_fifo.sv]
`timescale 1ns / 1ps
`include "stamp_alpha_blend_top_assert.svh"

module sab_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  sab_pkg::item_t push_item,
  output logic           push_ready,
  output logic           pop_valid,
  output sab_pkg::item_t pop_item,
  input  logic           pop_ready
);
  import sab_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  item_t            ent_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push;
  logic             pop;

  assign push_ready = cnt_r != CNT_W'(FIFO_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_item   = ent_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

  `SAB_ASSERT_IMP(a_ptr_gap, 1'b1, (wr_ptr_r - rd_ptr_r) == PTR_W'(cnt_r))
  `SAB_ASSERT_NXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + CNT_W'(1))
  `SAB_ASSERT_NXT(a_cnt_down, pop && !push, cnt_r == $past(cnt_r) - CNT_W'(1))

endmodule

[design/sab_blend.sv]
`timescale 1ns / 1ps
`include "stamp_alpha_blend_top_assert.svh"

module sab_blend (
  input  logic           clk,
  input  logic           rst_n,
  input  sab_pkg::cfg_t  cfg,
  input  logic           pop_valid,
  input  sab_pkg::item_t pop_item,
  output logic           pop_ready,
  sab_out_if.source      out_if
);
  import sab_pkg::*;

  localparam int NSTG = 6;

  logic                    adv;
  logic [NSTG-1:0]         vld_r, vld_nxt;
  logic                    out_v_r, out_v_nxt;
  logic [NSTG-1:0]         touch_r;
  logic [CH_NUM-1:0][15:0] d_r [NSTG];

  logic [15:0]             w1_r;
  logic [CH_NUM-1:0][23:0] cw2_r;
  logic [CH_NUM-1:0][31:0] dr2_r;
  logic [CH_NUM-1:0][31:0] t3_r;
  logic [CH_NUM-1:0][31:0] t4_r;
  logic [CH_NUM-1:0][56:0] p4_r;
  logic [CH_NUM-1:0][24:0] q5_r;
  logic [CH_NUM-1:0][24:0] q6_r;
  logic [CH_NUM-1:0][49:0] p6_r;
  out_t                    out_r;

  logic [8:0]              op_sat;
  logic [15:0]             w1_nxt;
  logic                    touch_nxt;
  logic [15:0]             rest;
  logic [CH_NUM-1:0][23:0] cw2_nxt;
  logic [CH_NUM-1:0][31:0] dr2_nxt;
  logic [CH_NUM-1:0][31:0] t3_nxt;
  logic [CH_NUM-1:0][56:0] p4_nxt;
  logic [CH_NUM-1:0][24:0] q5_nxt;
  logic [CH_NUM-1:0][49:0] p6_nxt;
  logic [CH_NUM-1:0][15:0] res_nxt;
  logic [39:0]             num;
  logic [24:0]             qe1;
  logic [32:0]             m1;
  logic [32:0]             r1;
  logic [17:0]             qe2;
  logic [17:0]             q2;
  logic [25:0]             m2;
  logic [25:0]             r2;
  logic [15:0]             mix;
  out_t                    out_nxt;

  assign adv       = !out_v_r || out_if.ready;
  assign pop_ready = adv;

  always_comb begin
    vld_nxt   = vld_r;
    out_v_nxt = out_v_r;
    if (adv) begin
      vld_nxt   = {vld_r[NSTG-2:0], pop_valid};
      out_v_nxt = vld_r[NSTG-1];
    end
  end

  // weight
  always_comb begin
    op_sat    = cfg.opacity_q8[8] ? 9'(OPACITY_FULL) : cfg.opacity_q8;
    w1_nxt    = {8'd0, pop_item.stamp} * {7'd0, op_sat};
    touch_nxt = (pop_item.stamp != 8'd0) && (op_sat != 9'd0);
    rest      = 16'(FULL_WEIGHT) - w1_r;
  end

  // per-channel datapath; divide by 255 = reciprocal multiply plus one correction
  always_comb begin
    num = '0;
    qe1 = '0;
    m1  = '0;
    r1  = '0;
    qe2 = '0;
    q2  = '0;
    m2  = '0;
    r2  = '0;
    mix = '0;
    for (int k = 0; k < CH_NUM; k++) begin
      cw2_nxt[k] = 24'(cfg.color[k]) * 24'(w1_r);
      dr2_nxt[k] = 32'(d_r[0][k]) * 32'(rest);

      if (cfg.deep_format) begin
        num = (40'(cw2_r[k]) << 15) + (40'(dr2_r[k]) << 8) - 40'(dr2_r[k])
            + 40'(ROUND16);
      end else begin
        num = 40'(cw2_r[k]) + 40'(dr2_r[k]) + 40'(ROUND8);
      end
      t3_nxt[k] = num[39:8];

      p4_nxt[k] = 57'(t3_r[k]) * 57'(RECIP_255);

      qe1 = p4_r[k][56:32];
      m1  = (33'(qe1) << 8) - 33'(qe1);
      r1  = 33'(t4_r[k]) - m1;
      q5_nxt[k] = (r1 >= 33'(DIV_BASE)) ? qe1 + 25'd1 : qe1;

      p6_nxt[k] = 50'(q5_r[k]) * 50'(RECIP_255);

      qe2 = p6_r[k][49:32];
      m2  = (26'(qe2) << 8) - 26'(qe2);
      r2  = 26'(q6_r[k]) - m2;
      q2  = (r2 >= 26'(DIV_BASE)) ? qe2 + 18'd1 : qe2;

      if (cfg.deep_format) begin
        mix = (q2 > 18'(CH_MAX16)) ? 16'(CH_MAX16) : q2[15:0];
      end else begin
        mix = (q6_r[k] > 25'(CH_MAX8)) ? 16'(CH_MAX8) : q6_r[k][15:0];
      end
      res_nxt[k] = touch_r[NSTG-1] ? mix : d_r[NSTG-1][k];
    end
  end

  always_comb begin
    out_nxt.out_red   = res_nxt[CH_RED];
    out_nxt.out_green = res_nxt[CH_GREEN];
    out_nxt.out_blue  = res_nxt[CH_BLUE];
    out_nxt.out_alpha = res_nxt[CH_ALPHA];
    out_nxt.touched   = touch_r[NSTG-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      vld_r   <= vld_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      touch_r <= {touch_r[NSTG-2:0], touch_nxt};
      d_r[0]  <= pop_item.dst;
      for (int s = 1; s < NSTG; s++) begin
        d_r[s] <= d_r[s-1];
      end
      w1_r  <= w1_nxt;
      cw2_r <= cw2_nxt;
      dr2_r <= dr2_nxt;
      t3_r  <= t3_nxt;
      t4_r  <= t3_r;
      p4_r  <= p4_nxt;
      q5_r  <= q5_nxt;
      q6_r  <= q5_r;
      p6_r  <= p6_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_if.valid = out_v_r;
  assign out_if.data  = out_r;

  `SAB_ASSERT_NXT(a_stall_hold, !adv, $stable(vld_r) && $stable(out_r))
  `SAB_ASSERT_IMP(a_clamp8, out_v_r && out_r.touched && !cfg.deep_format, (out_r.out_red <= 16'(CH_MAX8)) && (out_r.out_alpha <= 16'(CH_MAX8)))
  `SAB_ASSERT_IMP(a_clamp16, out_v_r && out_r.touched && cfg.deep_format, (out_r.out_green <= 16'(CH_MAX16)) && (out_r.out_blue <= 16'(CH_MAX16)))

endmodule

[design/stamp_alpha_blend_top.sv]
`timescale 1ns / 1ps

// Brush stamp blender. Load requests (func 0) write one coverage byte of the
// STAMP_SIDE x STAMP_SIDE stamp and return nothing; blend requests (func 1)
// return one pixel: the configured color mixed in by stamp * opacity when the
// pixel falls in the stamp window around (center_x, center_y), otherwise the
// destination unchanged with touched low. One request is taken per clock
// unless a full queue back-pressures the front; the single-port stamp
// store is read once per blend and the divide-by-255 blend datapath is
// fully pipelined. A four-entry queue between the lookup front and the
// blend pipeline absorbs stalls. The stamp store is not cleared at reset:
// entries must be loaded before a blend reads them. Configuration must be
// written only while no request is in flight; the block does not enforce it.

module stamp_alpha_blend_top #(
  parameter int STAMP_SIDE = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sab_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sab_pkg::CFG_W-1:0]      cfg_wdata,
  sab_in_if.sink                         in_if,
  sab_out_if.source                      out_if
);
  import sab_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  logic  q_push_valid;
  item_t q_push_item;
  logic  q_push_ready;
  logic  q_pop_valid;
  item_t q_pop_item;
  logic  q_pop_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_COLOR_RED:   cfg_nxt.color[CH_RED]   = cfg_wdata[7:0];
        REG_COLOR_GREEN: cfg_nxt.color[CH_GREEN] = cfg_wdata[7:0];
        REG_COLOR_BLUE:  cfg_nxt.color[CH_BLUE]  = cfg_wdata[7:0];
        REG_COLOR_ALPHA: cfg_nxt.color[CH_ALPHA] = cfg_wdata[7:0];
        REG_OPACITY:     cfg_nxt.opacity_q8      = cfg_wdata[8:0];
        REG_CENTER_X:    cfg_nxt.center_x        = $signed(cfg_wdata);
        REG_CENTER_Y:    cfg_nxt.center_y        = $signed(cfg_wdata);
        REG_DEEP_FORMAT: cfg_nxt.deep_format     = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.color[CH_RED]   <= 8'd0;
      cfg_r.color[CH_GREEN] <= 8'd0;
      cfg_r.color[CH_BLUE]  <= 8'd0;
      cfg_r.color[CH_ALPHA] <= 8'(CH_MAX8);
      cfg_r.opacity_q8      <= 9'(OPACITY_FULL);
      cfg_r.center_x        <= '0;
      cfg_r.center_y        <= '0;
      cfg_r.deep_format     <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sab_front #(
    .STAMP_SIDE (STAMP_SIDE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_if      (in_if),
    .push_valid (q_push_valid),
    .push_item  (q_push_item),
    .push_ready (q_push_ready)
  );

  sab_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_item  (q_push_item),
    .push_ready (q_push_ready),
    .pop_valid  (q_pop_valid),
    .pop_item   (q_pop_item),
    .pop_ready  (q_pop_ready)
  );

  sab_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (q_pop_valid),
    .pop_item  (q_pop_item),
    .pop_ready (q_pop_ready),
    .out_if    (out_if)
  );

endmodule
